/* hw/rtl/text_terminal_writer_core_defines.svh */
// Assertion macros shared by the text terminal writer checker.
// No dependencies; the using scope must provide clk and rst.
`ifndef TEXT_TERMINAL_WRITER_CORE_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TTW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TTW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ttw_pkg.sv */
// Shared types and constants for the text terminal writer.
// Used by the memory, the controller, the top level and the checker.
package ttw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);

  // field widths
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int CELL_W  = 16;

  // character codes and colors
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h0F;

  // request commands
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // controller states
  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_READ,
    S_COPY,
    S_RESP
  } state_t;

  // screen memory access from the controller
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

/* hw/rtl/ttw_ram.sv */
// Screen cell memory: one write port, one registered read port.
// Depends on ttw_pkg for geometry and the access struct.
module ttw_ram (
  input  logic                      clk,
  input  ttw_pkg::mem_req_t         mem_req,
  output logic [ttw_pkg::CELL_W-1:0] mem_rdata
);

  logic [ttw_pkg::CELL_W-1:0] mem [ttw_pkg::CELLS];

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    mem_rdata <= mem[mem_req.rd_addr];
  end

endmodule

/* hw/rtl/ttw_ctrl.sv */
// Command sequencer of the text terminal writer: cursor, color, fill/scroll sweeps
// and the output register. Depends on ttw_pkg; drives ttw_ram through mem_req_t.
module ttw_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [ttw_pkg::CHAR_W-1:0]  cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [ttw_pkg::CHAR_W-1:0]  character,
  input  logic [ttw_pkg::ROW_W-1:0]   read_row,
  input  logic [ttw_pkg::COL_W-1:0]   read_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ttw_pkg::CELL_W-1:0]  read_data,
  output logic [ttw_pkg::ROW_W-1:0]   cursor_row,
  output logic [ttw_pkg::COL_W-1:0]   cursor_col,
  output logic                        scrolled,
  output ttw_pkg::mem_req_t           mem_req,
  input  logic [ttw_pkg::CELL_W-1:0]  mem_rdata
);

  ttw_pkg::state_t                 state;
  ttw_pkg::state_t                 state_next;
  logic [ttw_pkg::CNT_W-1:0]       cnt;
  logic [ttw_pkg::CELL_W-1:0]      fill_cell;
  logic                            fill_reply;
  logic [ttw_pkg::ROW_W-1:0]       crow;
  logic [ttw_pkg::COL_W-1:0]       ccol;
  logic [ttw_pkg::CHAR_W-1:0]      text_color;
  logic                            read_hit;
  logic [ttw_pkg::CELL_W-1:0]      res_data;
  logic                            res_scrolled;

  logic                            accept;
  ttw_pkg::cmd_t                   cmd;
  logic                            nl;
  logic                            wrap;
  logic                            row_inc;
  logic                            scroll;
  logic [ttw_pkg::ROW_W-1:0]       put_row;
  logic [ttw_pkg::COL_W-1:0]       put_col;
  logic                            hit;
  logic                            out_load;

  // linear cell address of a row and column
  function automatic logic [ttw_pkg::ADDR_W-1:0] cell_addr(
    input logic [ttw_pkg::ROW_W-1:0] row,
    input logic [ttw_pkg::COL_W-1:0] col
  );
    cell_addr = ttw_pkg::ADDR_W'(ttw_pkg::ADDR_W'(row) * ttw_pkg::ADDR_W'(ttw_pkg::COLUMNS)
                + ttw_pkg::ADDR_W'(col));
  endfunction

  // request decode and cursor advance for put
  always_comb begin
    accept   = in_valid && in_ready;
    cmd      = ttw_pkg::cmd_t'(command);
    nl       = (character == ttw_pkg::NEWLINE_CHAR);
    wrap     = !nl && (ccol == ttw_pkg::COL_W'(ttw_pkg::COLUMNS - 1));
    row_inc  = nl || wrap;
    scroll   = row_inc && (crow == ttw_pkg::ROW_W'(ttw_pkg::ROWS - 1));
    put_row  = scroll ? ttw_pkg::ROW_W'(ttw_pkg::ROWS - 1)
                      : ttw_pkg::ROW_W'(crow + ttw_pkg::ROW_W'(row_inc));
    put_col  = row_inc ? '0 : ttw_pkg::COL_W'(ccol + 1'b1);
    hit      = (int'(read_row) < ttw_pkg::ROWS) && (int'(read_col) < ttw_pkg::COLUMNS);
    out_load = (state == ttw_pkg::S_RESP) && (!out_valid || out_ready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ttw_pkg::S_FILL: begin
        if (cnt == ttw_pkg::CNT_W'(ttw_pkg::CELLS - 1)) begin
          state_next = fill_reply ? ttw_pkg::S_RESP : ttw_pkg::S_IDLE;
        end
      end
      ttw_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            ttw_pkg::CMD_PUT:   state_next = scroll ? ttw_pkg::S_COPY : ttw_pkg::S_RESP;
            ttw_pkg::CMD_READ:  state_next = ttw_pkg::S_READ;
            ttw_pkg::CMD_CLEAR: state_next = ttw_pkg::S_FILL;
            default:            state_next = ttw_pkg::S_RESP;
          endcase
        end
      end
      ttw_pkg::S_READ: state_next = ttw_pkg::S_RESP;
      ttw_pkg::S_COPY: begin
        if (cnt == ttw_pkg::CNT_W'(ttw_pkg::CELLS)) begin
          state_next = ttw_pkg::S_FILL;
        end
      end
      ttw_pkg::S_RESP: begin
        if (!out_valid || out_ready) begin
          state_next = ttw_pkg::S_IDLE;
        end
      end
      default: state_next = ttw_pkg::S_IDLE;
    endcase
  end

  // handshake and memory port
  always_comb begin
    in_ready        = (state == ttw_pkg::S_IDLE);
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = cnt[ttw_pkg::ADDR_W-1:0];
    mem_req.wr_data = fill_cell;
    mem_req.rd_addr = cnt[ttw_pkg::ADDR_W-1:0];
    unique case (state)
      ttw_pkg::S_FILL: mem_req.wr_en = 1'b1;
      ttw_pkg::S_IDLE: begin
        mem_req.rd_addr = cell_addr(read_row, read_col);
        if (accept && cmd == ttw_pkg::CMD_PUT && !nl) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = cell_addr(crow, ccol);
          mem_req.wr_data = {text_color, character};
        end
      end
      // row r+1 read last cycle lands in row r
      ttw_pkg::S_COPY: begin
        mem_req.wr_en   = (cnt > ttw_pkg::CNT_W'(ttw_pkg::COLUMNS));
        mem_req.wr_addr = ttw_pkg::ADDR_W'(cnt - ttw_pkg::CNT_W'(ttw_pkg::COLUMNS + 1));
        mem_req.wr_data = mem_rdata;
      end
      ttw_pkg::S_READ, ttw_pkg::S_RESP: mem_req.wr_en = 1'b0;
      default: mem_req.wr_en = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ttw_pkg::S_FILL;
      cnt        <= '0;
      fill_cell  <= {ttw_pkg::RESET_COLOR, ttw_pkg::BLANK_CHAR};
      fill_reply <= 1'b0;
      crow       <= '0;
      ccol       <= '0;
      text_color <= ttw_pkg::RESET_COLOR;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        text_color <= cfg_write_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ttw_pkg::S_FILL: cnt <= ttw_pkg::CNT_W'(cnt + 1'b1);
        ttw_pkg::S_IDLE: begin
          if (accept && cmd == ttw_pkg::CMD_PUT) begin
            crow <= put_row;
            ccol <= put_col;
            cnt  <= ttw_pkg::CNT_W'(ttw_pkg::COLUMNS);
          end else if (accept && cmd == ttw_pkg::CMD_CLEAR) begin
            crow       <= '0;
            ccol       <= '0;
            cnt        <= '0;
            fill_cell  <= {text_color, ttw_pkg::BLANK_CHAR};
            fill_reply <= 1'b1;
          end
        end
        ttw_pkg::S_COPY: begin
          if (cnt == ttw_pkg::CNT_W'(ttw_pkg::CELLS)) begin
            // blank the bottom row next
            cnt        <= ttw_pkg::CNT_W'((ttw_pkg::ROWS - 1) * ttw_pkg::COLUMNS);
            fill_cell  <= {text_color, ttw_pkg::BLANK_CHAR};
            fill_reply <= 1'b1;
          end else begin
            cnt <= ttw_pkg::CNT_W'(cnt + 1'b1);
          end
        end
        ttw_pkg::S_READ, ttw_pkg::S_RESP: cnt <= cnt;
        default: cnt <= cnt;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ttw_pkg::S_IDLE && accept) begin
      res_data     <= '0;
      res_scrolled <= (cmd == ttw_pkg::CMD_PUT) && scroll;
      read_hit     <= hit;
    end
    if (state == ttw_pkg::S_READ) begin
      res_data <= read_hit ? mem_rdata : '0;
    end
    if (out_load) begin
      read_data  <= res_data;
      cursor_row <= crow;
      cursor_col <= ccol;
      scrolled   <= res_scrolled;
    end
  end

endmodule

/* hw/rtl/text_terminal_writer_core.sv */
// Text terminal writer top level: 80x25 screen of 16-bit cells with a write cursor.
// Built from ttw_ctrl and ttw_ram; types and geometry come from ttw_pkg.
//
// Usage:
//   Requests (command, character, read_row, read_col) enter on in_valid/in_ready;
//   one result (read_data, cursor_row, cursor_col, scrolled) leaves per request on
//   out_valid/out_ready. cfg_write_en/cfg_write_data set the text color at once.
//   On the way to out_valid, put and unused commands go straight to the result
//   state, read passes the read state first, clear first writes every cell (one
//   cell written per cycle), and a put that scrolls first has the single memory
//   port copy rows 1 to 24 up one cell per cycle, after a read lead-in, and
//   then blank the bottom row. One request is in work at a time; in_ready is
//   high only while the sequencer waits, and it rises again once the result is
//   in the output register, so the next request overlaps a result still
//   waiting to be taken.
//   Reset: the cursor homes, the color returns to 0x0F and a clearing pass
//   fills every cell with a blank; in_ready stays low meanwhile, while color
//   writes are still taken.
//   Stall: a held result keeps its output and the next finished result waits
//   in the sequencer until the output register frees.
module text_terminal_writer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [ttw_pkg::CHAR_W-1:0]  cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [ttw_pkg::CHAR_W-1:0]  character,
  input  logic [ttw_pkg::ROW_W-1:0]   read_row,
  input  logic [ttw_pkg::COL_W-1:0]   read_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ttw_pkg::CELL_W-1:0]  read_data,
  output logic [ttw_pkg::ROW_W-1:0]   cursor_row,
  output logic [ttw_pkg::COL_W-1:0]   cursor_col,
  output logic                        scrolled
);

  ttw_pkg::mem_req_t          mem_req;
  logic [ttw_pkg::CELL_W-1:0] mem_rdata;

  // sequencer
  ttw_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .character      (character),
    .read_row       (read_row),
    .read_col       (read_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .cursor_row     (cursor_row),
    .cursor_col     (cursor_col),
    .scrolled       (scrolled),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  // screen store
  ttw_ram u_ram (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule

/* hw/rtl/ttw_checker.sv */
// Port-level checks for text_terminal_writer_core, attached by bind.
// Depends on ttw_pkg and text_terminal_writer_core_defines.svh.
`include "text_terminal_writer_core_defines.svh"

module ttw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_write_en,
  input logic [ttw_pkg::CHAR_W-1:0]  cfg_write_data,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  command,
  input logic [ttw_pkg::CHAR_W-1:0]  character,
  input logic [ttw_pkg::ROW_W-1:0]   read_row,
  input logic [ttw_pkg::COL_W-1:0]   read_col,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ttw_pkg::CELL_W-1:0]  read_data,
  input logic [ttw_pkg::ROW_W-1:0]   cursor_row,
  input logic [ttw_pkg::COL_W-1:0]   cursor_col,
  input logic                        scrolled
);

  // a held result stays offered
  `TTW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data), "result dropped while stalled")

  // cursor on screen whenever a result is offered
  `TTW_ASSERT_IMP(a_cursor_range, out_valid, (int'(cursor_row) < ttw_pkg::ROWS) && (int'(cursor_col) < ttw_pkg::COLUMNS), "cursor off screen")

  // a scroll parks the cursor at the start of the bottom row
  `TTW_ASSERT_IMP(a_scroll_park, out_valid && scrolled, (int'(cursor_row) == ttw_pkg::ROWS - 1) && (cursor_col == '0), "scroll left cursor astray")

  // one request in work at a time
  `TTW_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken while busy")

endmodule

bind text_terminal_writer_core ttw_checker u_checker (.*);
